// ----- design/surviving_page_row_ranges_defines.svh -----
// surviving_page_row_ranges_defines.svh: assertion macros for the row range checker
// no dependencies; clk and rst must be visible where the macros are used
`ifndef SURVIVING_PAGE_ROW_RANGES_DEFINES_SVH
`define SURVIVING_PAGE_ROW_RANGES_DEFINES_SVH

// property checked only outside reset
`define SPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must also hold while reset is applied
`define SPR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/spr_pkg.sv -----
// spr_pkg: shared types and constants for the surviving page row range block
// no dependencies
package spr_pkg;

  // work steps that one accepted page hands from the front to the back
  typedef struct packed {
    logic resolve_prev;  // close the span of the previous kept page
    logic resolve_own;   // span of a kept last page, runs to the group size
    logic close_run;     // emit the closing item
  } step_t;

  localparam int STEP_BITS = $bits(step_t);
  localparam int OPQ_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

endpackage

// ----- design/surviving_page_row_ranges.sv -----
// surviving_page_row_ranges: pages of a column chunk in, merged surviving row ranges out
// depends on spr_pkg, spr_front, spr_opq and spr_back
//
// Usage: pages enter on a queue-style port (push/full), one column chunk after another,
// each with its first row, a keep bit and a last-page flag. Results leave on a queue-style
// port (empty/pop): each merged range of kept rows, then one closing item with run_done set.
// If the closing item has corrupt set, every range of that run is to be discarded.
// group_rows is written through cfg_wr_en/cfg_wr_data; the user must do so only while
// the block is idle, which the block does not enforce. Throughput: one page per cycle
// while the step queue is not full. The front classifies each page into at most three
// back steps (resolve previous span, resolve own span, close); the back executes one
// step a cycle while the result queue has room. A page's steps are registered in the
// step queue and its results in the result queue, which drives the result ports.
// A four-entry step queue sits between front and back, a two-entry result queue at the
// output; when pop is held low the result queue fills, the back stops, and full rises
// once the step queue is full. Nothing is lost.
// Reset (rst, synchronous) empties both queues, clears the run state and sets group_rows
// to zero.
module surviving_page_row_ranges import spr_pkg::*; #(
  parameter int ROW_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [ROW_BITS-1:0] page_first_row,
  input  logic                page_kept,
  input  logic                last_page,
  output logic                empty,
  input  logic                pop,
  output logic [ROW_BITS-1:0] range_start,
  output logic [ROW_BITS-1:0] range_rows,
  output logic                run_done,
  output logic                corrupt,
  input  logic                cfg_wr_en,
  input  logic [ROW_BITS-1:0] cfg_wr_data
);

  localparam int DW = STEP_BITS + 2 * ROW_BITS;

  logic [ROW_BITS-1:0] group_rows;
  logic                q_full;
  logic                q_wr;
  step_t               q_steps;
  logic [ROW_BITS-1:0] q_start;
  logic [ROW_BITS-1:0] q_first;
  logic [DW-1:0]       q_wdata;
  logic                q_rd;
  logic                q_valid;
  logic [DW-1:0]       q_rdata;
  step_t               rec_steps;
  logic [ROW_BITS-1:0] rec_start;
  logic [ROW_BITS-1:0] rec_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_rows <= '0;
    end else if (cfg_wr_en) begin
      group_rows <= cfg_wr_data;
    end
  end

  spr_front #(.ROW_BITS(ROW_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .q_full         (q_full),
    .page_first_row (page_first_row),
    .page_kept      (page_kept),
    .last_page      (last_page),
    .full           (full),
    .q_wr           (q_wr),
    .q_steps        (q_steps),
    .q_start        (q_start),
    .q_first        (q_first)
  );

  assign q_wdata = {q_steps, q_start, q_first};

  spr_opq #(.DW(DW), .DEPTH(OPQ_DEPTH)) u_opq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  assign rec_steps = step_t'(q_rdata[DW-1 -: STEP_BITS]);
  assign rec_start = q_rdata[2*ROW_BITS-1 -: ROW_BITS];
  assign rec_first = q_rdata[ROW_BITS-1:0];

  spr_back #(.ROW_BITS(ROW_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (q_valid),
    .rec_steps   (rec_steps),
    .rec_start   (rec_start),
    .rec_first   (rec_first),
    .group_rows  (group_rows),
    .rec_pop     (q_rd),
    .empty       (empty),
    .pop         (pop),
    .range_start (range_start),
    .range_rows  (range_rows),
    .run_done    (run_done),
    .corrupt     (corrupt)
  );

endmodule

// ----- design/spr_opq.sv -----
// spr_opq: small register queue between the front and the back
// depends on nothing but its parameters
module spr_opq #(
  parameter int DW    = 129,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output logic [DW-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/spr_front.sv -----
// spr_front: accepts pages, tracks the unresolved page and decides the back's steps
// depends on spr_pkg
module spr_front import spr_pkg::*; #(
  parameter int ROW_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                q_full,
  input  logic [ROW_BITS-1:0] page_first_row,
  input  logic                page_kept,
  input  logic                last_page,
  output logic                full,
  output logic                q_wr,
  output step_t               q_steps,
  output logic [ROW_BITS-1:0] q_start,
  output logic [ROW_BITS-1:0] q_first
);

  logic                prev_valid;
  logic                prev_kept;
  logic [ROW_BITS-1:0] prev_start;
  logic                take;

  assign full = q_full;
  assign take = push && !q_full;

  always_comb begin
    q_steps.resolve_prev = prev_valid && prev_kept;
    q_steps.resolve_own  = last_page && page_kept;
    q_steps.close_run    = last_page;
  end

  // a page that resolves nothing and does not close the run needs no back work
  assign q_wr    = take && (|q_steps);
  assign q_start = prev_start;
  assign q_first = page_first_row;

  always_ff @(posedge clk) begin
    if (take) begin
      prev_start <= page_first_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_kept  <= 1'b0;
    end else if (take) begin
      prev_valid <= !last_page;
      prev_kept  <= !last_page && page_kept;
    end
  end

endmodule

// ----- design/spr_back.sv -----
// spr_back: runs span checks and merging one step a cycle while the result queue has room, holds the result queue
// depends on spr_pkg
module spr_back import spr_pkg::*; #(
  parameter int ROW_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  input  step_t               rec_steps,
  input  logic [ROW_BITS-1:0] rec_start,
  input  logic [ROW_BITS-1:0] rec_first,
  input  logic [ROW_BITS-1:0] group_rows,
  output logic                rec_pop,
  output logic                empty,
  input  logic                pop,
  output logic [ROW_BITS-1:0] range_start,
  output logic [ROW_BITS-1:0] range_rows,
  output logic                run_done,
  output logic                corrupt
);

  localparam int OW = $clog2(OUT_DEPTH + 1);
  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

  // merge state
  logic                pend_valid;
  logic [ROW_BITS-1:0] pend_start;
  logic [ROW_BITS-1:0] pend_rows;
  logic [ROW_BITS-1:0] pend_end;
  logic                err;
  step_t               done_steps;

  // result queue
  logic [ROW_BITS-1:0] o_start [OUT_DEPTH];
  logic [ROW_BITS-1:0] o_rows  [OUT_DEPTH];
  logic                o_done  [OUT_DEPTH];
  logic                o_bad   [OUT_DEPTH];
  logic [PW-1:0]       o_wr_ptr;
  logic [PW-1:0]       o_rd_ptr;
  logic [OW-1:0]       o_count;

  step_t               remaining;
  step_t               sel;
  step_t               left_after;
  logic                fire;
  logic                do_resolve;
  logic [ROW_BITS-1:0] rs;
  logic [ROW_BITS-1:0] rn;
  logic                g_zero;
  logic                bad;
  logic [ROW_BITS-1:0] span_end;
  logic [ROW_BITS-1:0] cnt;
  logic                merge;
  logic                emit;
  logic [ROW_BITS-1:0] res_start;
  logic [ROW_BITS-1:0] res_rows;
  logic                res_done;
  logic                res_bad;
  logic                o_rd;

  always_comb begin
    remaining             = rec_steps & ~done_steps;
    sel.resolve_prev      = remaining.resolve_prev;
    sel.resolve_own       = !remaining.resolve_prev && remaining.resolve_own;
    sel.close_run         = !remaining.resolve_prev && !remaining.resolve_own &&
                            remaining.close_run;
    left_after            = remaining & ~sel;
    fire                  = rec_valid && (o_count != OW'(OUT_DEPTH));
    rec_pop               = fire && (left_after == '0);
    do_resolve            = sel.resolve_prev || sel.resolve_own;

    // previous page runs to this page's start, a last page to the group size
    rs       = sel.resolve_prev ? rec_start : rec_first;
    rn       = sel.resolve_prev ? rec_first : group_rows;
    g_zero   = (group_rows == '0);
    bad      = g_zero || (rn <= rs) || (rs >= group_rows);
    span_end = (rn < group_rows) ? rn : group_rows;
    cnt      = span_end - rs;
    merge    = pend_valid && (pend_end == rs);

    emit      = 1'b0;
    res_start = pend_start;
    res_rows  = pend_rows;
    res_done  = 1'b0;
    res_bad   = 1'b0;
    if (do_resolve) begin
      emit = !err && !bad && pend_valid && !merge;
    end else if (sel.close_run) begin
      emit     = 1'b1;
      res_done = 1'b1;
      if (err || g_zero) begin
        res_start = '0;
        res_rows  = '0;
        res_bad   = 1'b1;
      end else if (!pend_valid) begin
        res_start = '0;
        res_rows  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_resolve && !err && !bad) begin
      if (merge) begin
        pend_rows <= pend_rows + cnt;
      end else begin
        pend_start <= rs;
        pend_rows  <= cnt;
      end
      // contiguous spans: the merged end is always this span's end
      pend_end <= span_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      err        <= 1'b0;
      done_steps <= '0;
    end else if (fire) begin
      done_steps <= rec_pop ? step_t'('0) : (done_steps | sel);
      if (sel.close_run) begin
        pend_valid <= 1'b0;
        err        <= 1'b0;
      end else if (do_resolve && !err) begin
        if (bad) begin
          err <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  assign o_rd        = pop && !empty;
  assign empty       = (o_count == '0);
  assign range_start = o_start[o_rd_ptr];
  assign range_rows  = o_rows[o_rd_ptr];
  assign run_done    = o_done[o_rd_ptr];
  assign corrupt     = o_bad[o_rd_ptr];

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      o_start[o_wr_ptr] <= res_start;
      o_rows[o_wr_ptr]  <= res_rows;
      o_done[o_wr_ptr]  <= res_done;
      o_bad[o_wr_ptr]   <= res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr_ptr <= '0;
      o_rd_ptr <= '0;
      o_count  <= '0;
    end else begin
      if (fire && emit) begin
        o_wr_ptr <= (o_wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : o_wr_ptr + 1'b1;
      end
      if (o_rd) begin
        o_rd_ptr <= (o_rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : o_rd_ptr + 1'b1;
      end
      case ({fire && emit, o_rd})
        2'b10:   o_count <= o_count + 1'b1;
        2'b01:   o_count <= o_count - 1'b1;
        default: o_count <= o_count;
      endcase
    end
  end

endmodule

// ----- design/spr_checker.sv -----
// spr_checker: port-level assertions for surviving_page_row_ranges, bound to the top level
// depends on surviving_page_row_ranges_defines.svh
`include "surviving_page_row_ranges_defines.svh"

module spr_checker #(
  parameter int ROW_BITS = 63
) (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [ROW_BITS-1:0] range_start,
  input logic [ROW_BITS-1:0] range_rows,
  input logic                run_done,
  input logic                corrupt
);

  property p_corrupt_empty;
    !empty && corrupt |-> run_done && range_start == '0 && range_rows == '0;
  endproperty

  property p_out_hold;
    !empty && !pop |=> !empty && $stable(range_start) && $stable(range_rows) &&
      $stable(run_done) && $stable(corrupt);
  endproperty

  // a corrupt closing carries no range
  `SPR_ASSERT(a_corrupt_empty, p_corrupt_empty, "corrupt result not an empty closing item")

  // corrupt only ever marks the closing item
  `SPR_ASSERT(a_corrupt_closing, !empty && !run_done |-> !corrupt, "corrupt set on a range")

  // a merged range always covers at least one row
  `SPR_ASSERT(a_range_nonzero, !empty && !run_done |-> range_rows != '0, "range with zero rows")

  // a stalled result holds
  `SPR_ASSERT(a_out_hold, p_out_hold, "waiting result changed")

  // reset leaves the result queue empty and the step queue not full
  `SPR_ASSERT_RST(a_reset_idle, rst |=> empty && !full, "queues not empty after reset")

endmodule

bind surviving_page_row_ranges spr_checker #(.ROW_BITS(ROW_BITS)) u_spr_checker (.*);
